// ----- rtl/qwms_pkg.sv -----
// ----------------------------------------------------------------------------
// qwms_pkg: shared types and constants of the quadrotor motor mixer
// Payload structs, register reset values, fixed-point format and root sizing.
// ----------------------------------------------------------------------------
package qwms_pkg;

  localparam int unsigned InFracBits  = 16;
  localparam int unsigned OutFracBits = 8;
  // scale applied ahead of the root: square * 2^(2*OUT - IN)
  localparam int          RootShift   = 2 * OutFracBits - InFracBits;
  localparam int unsigned RadBits     = 48;  // radicand width
  localparam int unsigned SpeedBits   = 24;
  localparam int unsigned SqBits      = 68;  // signed squares and pair sums
  localparam int unsigned RootCells   = RadBits / 2;

  localparam logic [30:0] ThrustGainRst = 31'd31001;
  localparam logic [30:0] ArmGainRst    = 31'd364717;
  localparam logic [31:0] YawGainRst    = 32'hFFFC2F70;  // -250000

  typedef enum logic [1:0] {
    RegThrust = 2'd0,
    RegArm    = 2'd1,
    RegYaw    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] thrust;
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
  } wrench_t;

  typedef struct packed {
    logic [SpeedBits-1:0] speed_first;
    logic [SpeedBits-1:0] speed_second;
    logic [SpeedBits-1:0] speed_third;
    logic [SpeedBits-1:0] speed_fourth;
  } speeds_t;

  // partial state of four roots handed from cell to cell
  typedef struct packed {
    logic [3:0][RadBits-1:0]   rem;
    logic [3:0][RadBits-1:0]   rad;
    logic [3:0][SpeedBits-1:0] root;
    logic [3:0]                sat;
  } root_lane_t;

endpackage

// ----- rtl/qwms_root_cell.sv -----
// ----------------------------------------------------------------------------
// qwms_root_cell: one stage of the restoring square-root row
// Brings in two more radicand bits and decides one root bit for four lanes.
// ----------------------------------------------------------------------------
module qwms_root_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  qwms_pkg::root_lane_t           lane_i,
  output logic                           valid_o,
  output qwms_pkg::root_lane_t           lane_o
);
  import qwms_pkg::*;

  root_lane_t lane_d, lane_q;
  logic       valid_q;

  // one digit per lane: rem = rem*4 + next two bits, try (root*4+1)
  always_comb begin
    logic [RadBits+1:0] trial;
    logic [RadBits+1:0] cur;
    lane_d = lane_i;
    for (int l = 0; l < 4; l++) begin
      cur   = {lane_i.rem[l], lane_i.rad[l][RadBits-1 -: 2]};
      trial = {{(RadBits+2-SpeedBits-2){1'b0}}, lane_i.root[l], 2'b01};
      lane_d.rad[l] = {lane_i.rad[l][RadBits-3:0], 2'b00};
      if (cur >= trial) begin
        lane_d.rem[l]  = RadBits'(cur - trial);
        lane_d.root[l] = {lane_i.root[l][SpeedBits-2:0], 1'b1};
      end else begin
        lane_d.rem[l]  = cur[RadBits-1:0];
        lane_d.root[l] = {lane_i.root[l][SpeedBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
endmodule

// ----- rtl/qwms_mix.sv -----
// ----------------------------------------------------------------------------
// qwms_mix: gain products, mixing, pair correction and root radicands
// Two register stages: products, then sums/correction/scaling.
// ----------------------------------------------------------------------------
module qwms_mix (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  qwms_pkg::wrench_t    wrench_i,
  input  logic [30:0]          kf_i,
  input  logic [30:0]          ka_i,
  input  logic signed [31:0]   ky_i,
  output logic                 valid_o,
  output qwms_pkg::root_lane_t lane_o
);
  import qwms_pkg::*;

  logic signed [63:0] pf_q, px_q, py_q, pz_q;
  logic               v1_q, v2_q;
  root_lane_t         lane_d, lane_q;

  // stage 1: four 32x32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pf_q <= $signed({1'b0, kf_i}) * wrench_i.thrust;
      px_q <= $signed({1'b0, ka_i}) * wrench_i.roll_torque;
      py_q <= $signed({1'b0, ka_i}) * wrench_i.pitch_torque;
      pz_q <= ky_i * wrench_i.yaw_torque;
    end
  end

  function automatic logic [RadBits:0] rad_of(input logic signed [SqBits-1:0] x);
    logic [SqBits-1:0] u;
    logic [SqBits-1:0] s;
    u = x[SqBits-1] ? '0 : x;
    if (RootShift >= 0) s = u << RootShift;
    else                s = u >> (-RootShift);
    // saturation bit first when out of 48-bit range after scaling
    if (RootShift >= 0 && (u >> (RadBits - RootShift)) != '0) return {1'b1, {RadBits{1'b0}}};
    if (s[SqBits-1:RadBits] != '0) return {1'b1, {RadBits{1'b0}}};
    return {1'b0, s[RadBits-1:0]};
  endfunction

  // stage 2: mixing and pair correction
  always_comb begin
    logic signed [SqBits-1:0] w [4];
    logic signed [SqBits-1:0] f, x, y, z, a, b;
    logic [RadBits:0]         r;
    f = SqBits'(pf_q); x = SqBits'(px_q); y = SqBits'(py_q); z = SqBits'(pz_q);
    w[0] = f - y - z;
    w[1] = f + x + z;
    w[2] = f + y - z;
    w[3] = f - x + z;
    for (int p = 0; p < 2; p++) begin
      a = w[p]; b = w[p+2];
      if (a[SqBits-1] && b[SqBits-1]) begin
        a = '0; b = '0;
      end else if (a[SqBits-1]) begin
        b = b + a; a = '0;
      end else if (b[SqBits-1]) begin
        a = a + b; b = '0;
      end
      w[p] = a; w[p+2] = b;
    end
    lane_d = '0;
    // lanes ordered first..fourth = square 3..0
    for (int l = 0; l < 4; l++) begin
      r = rad_of(w[3-l]);
      lane_d.sat[l] = r[RadBits];
      lane_d.rad[l] = r[RadBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign lane_o  = lane_q;
  assign valid_o = v2_q;
endmodule

// ----- rtl/quadrotor_wrench_to_motor_speed.sv -----
// ----------------------------------------------------------------------------
// quadrotor_wrench_to_motor_speed: plus-configuration motor mixer
// 27 register stages: product stage, mix stage, 24 root cells, output register.
// Throughput one wrench per cycle; the whole row stalls together when the output
// is held. Reset clears valid bits and restores the three gain registers.
// ----------------------------------------------------------------------------
module quadrotor_wrench_to_motor_speed (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qwms_pkg::wrench_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qwms_pkg::speeds_t   out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import qwms_pkg::*;

  logic [30:0]        kf_q, ka_q;
  logic signed [31:0] ky_q;
  logic               en;
  logic [RootCells:0] v;
  root_lane_t         lane [RootCells+1];
  speeds_t            out_q;
  logic               out_v_q;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_q <= ThrustGainRst;
      ka_q <= ArmGainRst;
      ky_q <= YawGainRst;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegThrust: kf_q <= pwdata[30:0];
        RegArm:    ka_q <= pwdata[30:0];
        RegYaw:    ky_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThrust: prdata = {1'b0, kf_q};
      RegArm:    prdata = {1'b0, ka_q};
      RegYaw:    prdata = ky_q;
      default:   prdata = '0;
    endcase
  end

  // row advances unless a result waits
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  qwms_mix u_mix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .wrench_i(in_data_i),
    .kf_i(kf_q), .ka_i(ka_q), .ky_i(ky_q), .valid_o(v[0]), .lane_o(lane[0])
  );

  for (genvar c = 0; c < RootCells; c++) begin : g_cell
    qwms_root_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v[c]), .lane_i(lane[c]),
      .valid_o(v[c+1]), .lane_o(lane[c+1])
    );
  end

  // output register with saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v[RootCells];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.speed_first  <= lane[RootCells].sat[0] ? '1 : lane[RootCells].root[0];
      out_q.speed_second <= lane[RootCells].sat[1] ? '1 : lane[RootCells].root[1];
      out_q.speed_third  <= lane[RootCells].sat[2] ? '1 : lane[RootCells].root[2];
      out_q.speed_fourth <= lane[RootCells].sat[3] ? '1 : lane[RootCells].root[3];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

// ----- rtl/qwms_checker.sv -----
// ----------------------------------------------------------------------------
// qwms_checker: port-level checks of the motor mixer
// Handshake holding and backpressure coupling.
// ----------------------------------------------------------------------------
module qwms_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input qwms_pkg::speeds_t out_data_o
);
  import qwms_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
endmodule

bind quadrotor_wrench_to_motor_speed qwms_checker u_qwms_checker (.*);

// ----- dv/tb_quadrotor_wrench_to_motor_speed.sv -----
// ----------------------------------------------------------------------------
// tb_quadrotor_wrench_to_motor_speed: self-checking bench for the motor mixer
// Drives wrenches over valid/ready with random idling on both sides, writes
// the three gain registers over APB between phases, and compares every
// speed beat against an in-bench mixer/root predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrotor_wrench_to_motor_speed;
  import qwms_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  wrench_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  speeds_t     out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quadrotor_wrench_to_motor_speed DUT (.*);

  // predictor copy of the gains
  logic        [30:0] kf_q;
  logic        [30:0] ka_q;
  logic signed [31:0] ky_q;

  speeds_t     speeds_due[$];
  int unsigned error_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_cnt++;
  endtask

  // floor square root of a 48 bit radicand
  function automatic logic [23:0] root_floor(input logic [47:0] rad);
    logic [47:0] r;
    logic [47:0] t;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (48'd1 << b);
      if (t * t <= rad) r = t;
    end
    return r[23:0];
  endfunction

  function automatic logic [23:0] speed_of_square(input logic signed [67:0] sq);
    logic [67:0] scaled;
    if (sq < 0) return '0;
    if (RootShift >= 0) scaled = sq <<< RootShift;
    else scaled = sq >>> (-RootShift);
    if (scaled[67:48] != 0) return 24'hFFFFFF;
    return root_floor(scaled[47:0]);
  endfunction

  function automatic void fix_pair(inout logic signed [67:0] a,
                                   inout logic signed [67:0] b);
    if (a < 0 && b < 0) begin
      a = 0;
      b = 0;
      return;
    end
    if (a < 0) begin
      b = b + a;
      a = 0;
    end
    if (b < 0) begin
      a = a + b;
      b = 0;
    end
  endfunction

  function automatic speeds_t mix_wrench(input wrench_t w);
    logic signed [67:0] ft, ax, ay, yz;
    logic signed [67:0] sq[4];
    speeds_t s;
    ft = $signed({37'd0, kf_q}) * 68'(w.thrust);
    ax = $signed({37'd0, ka_q}) * 68'(w.roll_torque);
    ay = $signed({37'd0, ka_q}) * 68'(w.pitch_torque);
    yz = 68'(ky_q) * 68'(w.yaw_torque);
    sq[0] = ft - ay - yz;
    sq[1] = ft + ax + yz;
    sq[2] = ft + ay - yz;
    sq[3] = ft - ax + yz;
    fix_pair(sq[0], sq[2]);
    fix_pair(sq[1], sq[3]);
    s.speed_first  = speed_of_square(sq[3]);
    s.speed_second = speed_of_square(sq[2]);
    s.speed_third  = speed_of_square(sq[1]);
    s.speed_fourth = speed_of_square(sq[0]);
    return s;
  endfunction

  // one wrench beat; prediction taken at acceptance
  task automatic send_wrench(input wrench_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    speeds_due.push_back(mix_wrench(w));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // setup then access cycle; the caller closes the transfer
  task automatic write_gain(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegThrust: kf_q = val[30:0];
      RegArm:    ka_q = val[30:0];
      default:   ky_q = val;
    endcase
  endtask

  task automatic set_gains(input logic [31:0] kf, input logic [31:0] ka,
                           input logic [31:0] ky);
    wait_drained();
    write_gain(RegThrust, kf);
    write_gain(RegArm, ka);
    write_gain(RegYaw, ky);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(65535) << 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic wrench_t rand_wrench(input logic bool_like);
    wrench_t w;
    w.thrust       = pick_field();
    w.roll_torque  = pick_field();
    w.pitch_torque = pick_field();
    w.yaw_torque   = pick_field();
    // mostly hover-like wrenches: positive thrust, modest torques
    if (bool_like) begin
      w.thrust       = $urandom_range(32'h00200000);
      w.roll_torque  = $signed(32'($urandom_range(32'h8000))) - 32'sh4000;
      w.pitch_torque = $signed(32'($urandom_range(32'h8000))) - 32'sh4000;
      w.yaw_torque   = $signed(32'($urandom_range(32'h20000))) - 32'sh10000;
    end
    return w;
  endfunction

  task automatic test_directed_extremes();
    logic [31:0] ext[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    wrench_t w;
    for (int i = 0; i < 4; i++) begin
      w = '{ext[i], ext[i], ext[i], ext[i]};
      send_wrench(w);
    end
    // hover, single axis torques, both-negative pair, one-negative spill
    send_wrench('{32'h00100000, 32'h0, 32'h0, 32'h0});
    send_wrench('{32'h00100000, 32'h00010000, 32'h0, 32'h0});
    send_wrench('{32'h00100000, 32'h0, 32'hFFFF0000, 32'h0});
    send_wrench('{32'h00100000, 32'h0, 32'h0, 32'h00100000});
    send_wrench('{32'hFFF00000, 32'h0, 32'h00010000, 32'h0});
    send_wrench('{32'h00010000, 32'h0, 32'h00100000, 32'h0});
    send_wrench('{32'h00010000, 32'h00100000, 32'h0, 32'h0});
    send_wrench('{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0});
    send_wrench('{32'h00000001, 32'h0, 32'h0, 32'h0});
  endtask

  task automatic test_random_wrenches(input int n);
    for (int i = 0; i < n; i++) send_wrench(rand_wrench($urandom_range(3) != 0));
  endtask

  task automatic test_gain_settings();
    set_gains(32'd0, 32'd0, 32'd0);
    test_random_wrenches(30);
    set_gains(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    test_random_wrenches(40);
    set_gains(32'd1, 32'd1, 32'h80000000);
    test_random_wrenches(40);
    set_gains($urandom(), $urandom(), $urandom());
    test_random_wrenches(40);
    set_gains(32'd31001, 32'd364717, 32'hFFFC2F70);
  endtask

  // check every result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (speeds_due.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o.speed_first, 24'd0);
      end else begin
        speeds_t e;
        e = speeds_due.pop_front();
        if (out_data_o.speed_first !== e.speed_first)
          report_mismatch("speed_first", out_data_o.speed_first, e.speed_first);
        if (out_data_o.speed_second !== e.speed_second)
          report_mismatch("speed_second", out_data_o.speed_second, e.speed_second);
        if (out_data_o.speed_third !== e.speed_third)
          report_mismatch("speed_third", out_data_o.speed_third, e.speed_third);
        if (out_data_o.speed_fourth !== e.speed_fourth)
          report_mismatch("speed_fourth", out_data_o.speed_fourth, e.speed_fourth);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  // watchdog on beats in either direction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchdogLimit) begin
      $display("tb_quadrotor_wrench_to_motor_speed: done, errors");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 76;
    kf_q = ThrustGainRst;
    ka_q = ArmGainRst;
    ky_q = YawGainRst;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_wrenches(150);
    // hold-off until the pipe is empty
    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 18;
    test_gain_settings();
    test_random_wrenches(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_wrenches(220);

    wait_drained();
    if (error_cnt == 0) $display("tb_quadrotor_wrench_to_motor_speed: done, clean");
    else $display("tb_quadrotor_wrench_to_motor_speed: done, errors");
    $finish;
  end

endmodule
